[hdl/tcb_pkg.sv]
// tcb_pkg: shared types and constants of the transparent clipped blit
// used by every module of the block, depends on nothing

package tcb_pkg;

   // fixed field widths
   localparam int ADDR_W      = 16;
   localparam int COLOUR_W    = 8;
   localparam int OFFSET_W    = 11;
   localparam int SIZE_W      = 10;
   localparam int CLIP_W      = 8;
   localparam int POS_W       = 12;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 11;

   // reset value of the exclusive bottom clip row
   localparam logic [CLIP_W-1:0] CLIP_BOTTOM_RESET = 8'd200;

   // register indexes of the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_DEST_X        = 3'd0,
      REG_DEST_Y        = 3'd1,
      REG_SOURCE_WIDTH  = 3'd2,
      REG_SOURCE_HEIGHT = 3'd3,
      REG_KEY_COLOUR    = 3'd4,
      REG_CLIP_TOP      = 3'd5,
      REG_CLIP_BOTTOM   = 3'd6
   } csr_index_type;

   // configuration registers as seen by the front end
   typedef struct packed {
      logic [OFFSET_W-1:0] dest_x;
      logic [OFFSET_W-1:0] dest_y;
      logic [SIZE_W-1:0]   source_width;
      logic [SIZE_W-1:0]   source_height;
      logic [COLOUR_W-1:0] key_colour;
      logic [CLIP_W-1:0]   clip_top;
      logic [CLIP_W-1:0]   clip_bottom;
   } cfg_type;

   // queue status between the queue and its two sides
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

[hdl/tcb_front.sv]
// tcb_front: source position counters and clip/key classification
// depends on tcb_pkg; feeds surviving words into tcb_queue

module tcb_front #(
   parameter int FRAME_WIDTH  = 320,
   parameter int FRAME_HEIGHT = 200,
   parameter int COL_W        = 9,
   parameter int ROW_W        = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tcb_pkg::cfg_type             cfg,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [tcb_pkg::COLOUR_W-1:0] req_source_pixel,
   input  tcb_pkg::queue_status_type    q_status,
   output logic                         q_push,
   output logic [tcb_pkg::COLOUR_W+ROW_W+COL_W-1:0] q_data
);

   localparam int P_W = tcb_pkg::POS_W;
   localparam int S_W = tcb_pkg::SIZE_W;
   localparam logic signed [P_W-1:0] COL_LIMIT = P_W'(FRAME_WIDTH - 1);
   localparam logic signed [P_W-1:0] ROW_LIMIT = P_W'(FRAME_HEIGHT - 1);

   logic [S_W-1:0]          column_count_ff, column_count_in;
   logic [S_W-1:0]          row_count_ff, row_count_in;
   logic signed [P_W-1:0]   col_pos;
   logic signed [P_W-1:0]   row_pos;
   logic signed [P_W-1:0]   clip_top_pos;
   logic signed [P_W-1:0]   clip_bottom_pos;
   logic                    in_source;
   logic                    on_screen;
   logic                    in_clip;
   logic                    accept;
   logic [S_W:0]            col_inc;
   logic [S_W:0]            row_inc;

   // destination position of the current pixel
   assign col_pos = $signed({cfg.dest_x[tcb_pkg::OFFSET_W-1], cfg.dest_x})
                  + $signed({2'b00, column_count_ff});
   assign row_pos = $signed({cfg.dest_y[tcb_pkg::OFFSET_W-1], cfg.dest_y})
                  + $signed({2'b00, row_count_ff});
   assign clip_top_pos    = $signed({4'b0000, cfg.clip_top});
   assign clip_bottom_pos = $signed({4'b0000, cfg.clip_bottom});

   // classification
   assign in_source = (column_count_ff < cfg.source_width) &&
                      (row_count_ff < cfg.source_height);
   assign on_screen = (col_pos >= 0) && (col_pos < COL_LIMIT) &&
                      (row_pos >= 0) && (row_pos < ROW_LIMIT);
   assign in_clip   = (row_pos >= clip_top_pos) && (row_pos < clip_bottom_pos);

   assign req_full = q_status.full;
   assign accept   = req_push && !q_status.full;
   assign q_push   = accept && in_source && on_screen && in_clip &&
                     (req_source_pixel != cfg.key_colour);
   assign q_data   = {req_source_pixel, row_pos[ROW_W-1:0], col_pos[COL_W-1:0]};

   // raster counter advance
   always_comb begin
      col_inc         = {1'b0, column_count_ff} + 1'b1;
      row_inc         = {1'b0, row_count_ff} + 1'b1;
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (accept) begin
         if (col_inc >= {1'b0, cfg.source_width}) begin
            column_count_in = '0;
            if (row_inc >= {1'b0, cfg.source_height}) begin
               row_count_in = '0;
            end else begin
               row_count_in = row_inc[S_W-1:0];
            end
         end else begin
            column_count_in = col_inc[S_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
      end
   end

endmodule

[hdl/tcb_queue.sv]
// tcb_queue: short register queue between front and back end
// depends on tcb_pkg for the status struct

module tcb_queue #(
   parameter int WIDTH = 25,
   parameter int DEPTH = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [WIDTH-1:0]          push_data,
   input  logic                      pop,
   output logic [WIDTH-1:0]          pop_data,
   output tcb_pkg::queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = slot_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hdl/tcb_back.sv]
// tcb_back: address multiply and the result output register
// depends on tcb_pkg; drains words from tcb_queue

module tcb_back #(
   parameter int FRAME_WIDTH = 320,
   parameter int COL_W       = 9,
   parameter int ROW_W       = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tcb_pkg::queue_status_type    q_status,
   input  logic [tcb_pkg::COLOUR_W+ROW_W+COL_W-1:0] q_data,
   output logic                         q_pop,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [tcb_pkg::ADDR_W-1:0]   rsp_write_address,
   output logic [tcb_pkg::COLOUR_W-1:0] rsp_write_colour
);

   localparam int A_W    = tcb_pkg::ADDR_W;
   localparam int NAT_W  = ROW_W + COL_W + 1;
   localparam int PROD_W = (NAT_W > A_W) ? NAT_W : A_W;

   logic                         out_valid_ff, out_valid_in;
   logic [A_W-1:0]               address_ff, address_in;
   logic [tcb_pkg::COLOUR_W-1:0] colour_ff, colour_in;
   logic [COL_W-1:0]             col;
   logic [ROW_W-1:0]             row;
   logic [PROD_W-1:0]            prod;
   logic                         load;

   // unpack the queued word
   assign col = q_data[COL_W-1:0];
   assign row = q_data[ROW_W+COL_W-1:COL_W];

   // refill the output register when it is free or being taken
   assign load  = !q_status.empty && (!out_valid_ff || rsp_pop);
   assign q_pop = load;
   assign prod  = PROD_W'(row) * PROD_W'(FRAME_WIDTH) + PROD_W'(col);

   always_comb begin
      out_valid_in = out_valid_ff;
      address_in   = address_ff;
      colour_in    = colour_ff;
      if (load) begin
         out_valid_in = 1'b1;
         address_in   = prod[A_W-1:0];
         colour_in    = q_data[tcb_pkg::COLOUR_W+ROW_W+COL_W-1:ROW_W+COL_W];
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      address_ff <= address_in;
      colour_ff  <= colour_in;
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_write_address = address_ff;
   assign rsp_write_colour  = colour_ff;

endmodule

[hdl/transparent_clipped_blit.sv]
// transparent_clipped_blit: top level, configuration registers and assertions
// depends on tcb_pkg, tcb_front, tcb_queue and tcb_back
//
// Usage:
// - source pixels enter in raster order on the req_ queue port: a word is
//   taken at a clock edge with req_push high and req_full low
// - each pixel that lands on screen, inside the clip rows and differs from
//   the key colour gives one frame buffer write on the rsp_ port; the oldest
//   write waits there while rsp_empty is low and leaves on rsp_pop
// - the csr_ port writes the seven registers (index, data); csr_ready is
//   always high; write it only while no pixel is in flight
// - a kept pixel is written into the queue at the edge that takes it, then
//   goes through the address multiply into the output register once that
//   register is free or being taken
// - throughput: one pixel per cycle while req_full is low, set by the front
//   end's combinational classify and the one-word-per-cycle back-end drain
// - a stalled receiver holds the output word; up to four kept pixels then
//   collect in the middle queue before req_full rises
// - reset clears the counters, the queue and the output register and loads
//   register defaults (clip_bottom 200, all others 0)

module transparent_clipped_blit #(
   parameter int FRAME_WIDTH  = 320,
   parameter int FRAME_HEIGHT = 200
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [tcb_pkg::COLOUR_W-1:0]    req_source_pixel,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [tcb_pkg::ADDR_W-1:0]      rsp_write_address,
   output logic [tcb_pkg::COLOUR_W-1:0]    rsp_write_colour,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tcb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tcb_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int COL_W   = $clog2(FRAME_WIDTH);
   localparam int ROW_W   = $clog2(FRAME_HEIGHT);
   localparam int Q_W     = tcb_pkg::COLOUR_W + ROW_W + COL_W;
   localparam int Q_DEPTH = 4;

   // register defaults after reset
   localparam tcb_pkg::cfg_type CFG_RESET = '{
      dest_x:        '0,
      dest_y:        '0,
      source_width:  '0,
      source_height: '0,
      key_colour:    '0,
      clip_top:      '0,
      clip_bottom:   tcb_pkg::CLIP_BOTTOM_RESET
   };

   tcb_pkg::cfg_type          cfg_ff, cfg_in;
   tcb_pkg::queue_status_type q_status;
   logic                      q_push;
   logic                      q_pop;
   logic [Q_W-1:0]            q_push_data;
   logic [Q_W-1:0]            q_pop_data;

   assign csr_ready = 1'b1;

   // configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (tcb_pkg::csr_index_type'(csr_index))
            tcb_pkg::REG_DEST_X:        cfg_in.dest_x        = csr_data;
            tcb_pkg::REG_DEST_Y:        cfg_in.dest_y        = csr_data;
            tcb_pkg::REG_SOURCE_WIDTH:  cfg_in.source_width  = csr_data[9:0];
            tcb_pkg::REG_SOURCE_HEIGHT: cfg_in.source_height = csr_data[9:0];
            tcb_pkg::REG_KEY_COLOUR:    cfg_in.key_colour    = csr_data[7:0];
            tcb_pkg::REG_CLIP_TOP:      cfg_in.clip_top      = csr_data[7:0];
            tcb_pkg::REG_CLIP_BOTTOM:   cfg_in.clip_bottom   = csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: counters and classification
   tcb_front #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT),
      .COL_W        (COL_W),
      .ROW_W        (ROW_W)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_source_pixel (req_source_pixel),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_data           (q_push_data)
   );

   // decoupling queue
   tcb_queue #(
      .WIDTH (Q_W),
      .DEPTH (Q_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   // back end: address and output register
   tcb_back #(
      .FRAME_WIDTH (FRAME_WIDTH),
      .COL_W       (COL_W),
      .ROW_W       (ROW_W)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_status          (q_status),
      .q_data            (q_pop_data),
      .q_pop             (q_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_write_address (rsp_write_address),
      .rsp_write_colour  (rsp_write_colour)
   );

   // reset leaves no result and a free queue
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (rsp_empty && !q_status.full))
      else $error("result or full queue right after reset");

   // a waiting result holds until taken
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_write_address) && $stable(rsp_write_colour)))
      else $error("waiting result changed or vanished");

   // no result appears without a queued word
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      (q_status.empty && rsp_empty) |=> rsp_empty)
      else $error("result appeared from an empty queue");

endmodule

[verif/tb_transparent_clipped_blit.sv]
// tb_transparent_clipped_blit: self-checking testbench of the colour-keyed clipped blit
// needs tcb_pkg and the transparent_clipped_blit rtl, nothing else
// directed edge and clip cases, a receiver hold-off, then random placements under idling

`timescale 1ns / 1ps

module tb_transparent_clipped_blit;

   localparam int FRAME_WIDTH   = 320;
   localparam int FRAME_HEIGHT  = 200;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 120;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_PIXELS  = 75;
   localparam int PRESSURE_PIXELS = 60;
   localparam int TIMEOUT_NS    = 400000;

   // index past the register list, written to check that it is ignored
   localparam logic [tcb_pkg::CSR_INDEX_W-1:0] REG_UNUSED = 3'd7;

   typedef enum logic {STEP_REGISTER, STEP_PIXEL} step_kind_type;
   typedef enum logic [1:0] {CHK_PREDICTED, CHK_SKIPPED, CHK_WRITE} pixel_check_type;

   typedef struct {
      step_kind_type                     kind;
      logic [tcb_pkg::CSR_INDEX_W-1:0]   index;
      logic [tcb_pkg::CSR_DATA_W-1:0]    data;
      logic [tcb_pkg::COLOUR_W-1:0]      pixel;
      pixel_check_type                   check;
      logic [tcb_pkg::ADDR_W-1:0]        address;
   } script_step_type;

   typedef struct packed {
      logic [tcb_pkg::ADDR_W-1:0]   address;
      logic [tcb_pkg::COLOUR_W-1:0] colour;
   } frame_write_type;

   // dut ports
   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_push = 1'b0;
   logic                            req_full;
   logic [tcb_pkg::COLOUR_W-1:0]    req_source_pixel = '0;
   logic                            rsp_empty;
   logic                            rsp_pop = 1'b0;
   logic [tcb_pkg::ADDR_W-1:0]      rsp_write_address;
   logic [tcb_pkg::COLOUR_W-1:0]    rsp_write_colour;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [tcb_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [tcb_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   // predictor copy of the registers and the raster counters
   logic [tcb_pkg::OFFSET_W-1:0] blit_dest_x = '0;
   logic [tcb_pkg::OFFSET_W-1:0] blit_dest_y = '0;
   logic [tcb_pkg::SIZE_W-1:0]   source_width = '0;
   logic [tcb_pkg::SIZE_W-1:0]   source_height = '0;
   logic [tcb_pkg::COLOUR_W-1:0] key_colour = '0;
   logic [tcb_pkg::CLIP_W-1:0]   clip_top = '0;
   logic [tcb_pkg::CLIP_W-1:0]   clip_bottom = tcb_pkg::CLIP_BOTTOM_RESET;
   logic [tcb_pkg::SIZE_W-1:0]   column_count = '0;
   logic [tcb_pkg::SIZE_W-1:0]   row_count = '0;

   frame_write_type   pending_writes[$];
   script_step_type   script[$];
   pixel_check_type   row_check = CHK_PREDICTED;
   logic [tcb_pkg::ADDR_W-1:0] row_address = '0;

   int error_count = 0;
   int pixels_taken = 0;
   int writes_checked = 0;
   int register_writes = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_requests = 0;

   transparent_clipped_blit #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_source_pixel  (req_source_pixel),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_write_address (rsp_write_address),
      .rsp_write_colour  (rsp_write_colour),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // placement of one pixel: returns whether it is written, advances the raster counters
   function automatic logic place_pixel(input logic [tcb_pkg::COLOUR_W-1:0] pixel,
                                        output logic [tcb_pkg::ADDR_W-1:0] address);
      int col;
      int row;
      int col_now;
      int row_now;
      int wide;
      int tall;
      int top;
      int bottom;
      logic kept;
      col     = $signed(blit_dest_x);
      row     = $signed(blit_dest_y);
      col_now = column_count;
      row_now = row_count;
      wide    = source_width;
      tall    = source_height;
      top     = clip_top;
      bottom  = clip_bottom;
      col     = col + col_now;
      row     = row + row_now;
      // last drawn column and row sit two short of the frame size
      kept = col_now < wide && row_now < tall &&
             col >= 0 && col < FRAME_WIDTH - 1 &&
             row >= 0 && row < FRAME_HEIGHT - 1 &&
             row >= top && row < bottom && pixel != key_colour;
      address = tcb_pkg::ADDR_W'(row * FRAME_WIDTH + col);
      // raster advance, wrapping at or past the source size
      if (col_now + 1 >= wide) begin
         column_count = '0;
         if (row_now + 1 >= tall)
            row_count = '0;
         else
            row_count = row_count + 1'b1;
      end else begin
         column_count = column_count + 1'b1;
      end
      return kept;
   endfunction

   // register write as the block sees it, masked to each register's width
   function automatic void apply_register(input logic [tcb_pkg::CSR_INDEX_W-1:0] index,
                                          input logic [tcb_pkg::CSR_DATA_W-1:0] data);
      case (index)
         tcb_pkg::REG_DEST_X:        blit_dest_x   = data[tcb_pkg::OFFSET_W-1:0];
         tcb_pkg::REG_DEST_Y:        blit_dest_y   = data[tcb_pkg::OFFSET_W-1:0];
         tcb_pkg::REG_SOURCE_WIDTH:  source_width  = data[tcb_pkg::SIZE_W-1:0];
         tcb_pkg::REG_SOURCE_HEIGHT: source_height = data[tcb_pkg::SIZE_W-1:0];
         tcb_pkg::REG_KEY_COLOUR:    key_colour    = data[tcb_pkg::COLOUR_W-1:0];
         tcb_pkg::REG_CLIP_TOP:      clip_top      = data[tcb_pkg::CLIP_W-1:0];
         tcb_pkg::REG_CLIP_BOTTOM:   clip_bottom   = data[tcb_pkg::CLIP_W-1:0];
         default: ;
      endcase
   endfunction

   // scoreboard: check popped words, predict taken pixels, track register writes
   always @(posedge clock) begin : scoreboard
      frame_write_type want;
      logic [tcb_pkg::ADDR_W-1:0] address;
      logic kept;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (pending_writes.size() == 0) begin
               error_count++;
               $display("%0d ns: unexpected write word, expected none, %s %0d colour %0d",
                        $time, "actual address", rsp_write_address, rsp_write_colour);
            end else begin
               want = pending_writes.pop_front();
               writes_checked++;
               if (rsp_write_address !== want.address) begin
                  error_count++;
                  $display("%0d ns: write_address mismatch, expected %0d, actual %0d",
                           $time, want.address, rsp_write_address);
               end
               if (rsp_write_colour !== want.colour) begin
                  error_count++;
                  $display("%0d ns: write_colour mismatch, expected %0d, actual %0d",
                           $time, want.colour, rsp_write_colour);
               end
            end
         end
         if (req_push && !req_full) begin
            pixels_taken++;
            kept = place_pixel(req_source_pixel, address);
            // typed-in rows override the predicted outcome
            case (row_check)
               CHK_PREDICTED: if (kept) pending_writes.push_back({address, req_source_pixel});
               CHK_WRITE:     pending_writes.push_back({row_address, req_source_pixel});
               default: ;
            endcase
         end
         if (csr_valid && csr_ready) begin
            register_writes++;
            apply_register(csr_index, csr_data);
         end
      end
   end

   // receiver: random stalls, plus long hold-offs counted here
   initial begin : receiver
      int hold_left;
      int holds_served;
      hold_left = 0;
      holds_served = 0;
      forever begin
         @(negedge clock);
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(0, 99) >= receiver_stall_pct);
         end
      end
   end

   // offer one pixel, leaving push high after it is taken
   task automatic send_pixel(input logic [tcb_pkg::COLOUR_W-1:0] pixel,
                             input pixel_check_type check,
                             input logic [tcb_pkg::ADDR_W-1:0] address);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push         <= 1'b1;
      req_source_pixel <= pixel;
      row_check        <= check;
      row_address      <= address;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   // stop offering, wait for every pending word, then let the pipe empty
   task automatic settle_block();
      @(negedge clock);
      req_push <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [tcb_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [tcb_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_register(input logic [tcb_pkg::CSR_INDEX_W-1:0] index,
                               input logic [tcb_pkg::CSR_DATA_W-1:0] data);
      script_step_type step;
      step = '{STEP_REGISTER, index, data, '0, CHK_PREDICTED, '0};
      script.push_back(step);
   endtask

   task automatic add_pixel(input logic [tcb_pkg::COLOUR_W-1:0] pixel,
                            input pixel_check_type check,
                            input logic [tcb_pkg::ADDR_W-1:0] address);
      script_step_type step;
      step = '{STEP_PIXEL, '0, '0, pixel, check, address};
      script.push_back(step);
   endtask

   // run time limit
   initial begin
      #(TIMEOUT_NS);
      $display("Regression FAIL");
      $finish;
   end

   // main sequence
   initial begin : stimulus
      int dx;
      int dy;
      int w;
      int h;
      int ct;
      int cb;
      logic [tcb_pkg::COLOUR_W-1:0] phase_key;
      logic [tcb_pkg::COLOUR_W-1:0] pixel;
      logic after_pixel;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // after reset: empty source, nothing written
      add_pixel(8'hA5, CHK_SKIPPED, '0);
      // 3x3 source at the bottom right corner: last drawn column 318, row 198
      add_register(tcb_pkg::REG_DEST_X, 11'd317);
      add_register(tcb_pkg::REG_DEST_Y, 11'd197);
      add_register(tcb_pkg::REG_SOURCE_WIDTH, 11'd3);
      add_register(tcb_pkg::REG_SOURCE_HEIGHT, 11'd3);
      add_register(tcb_pkg::REG_KEY_COLOUR, 11'd0);
      add_register(tcb_pkg::REG_CLIP_TOP, 11'd0);
      add_register(tcb_pkg::REG_CLIP_BOTTOM, 11'd200);
      add_pixel(8'hFF, CHK_WRITE, 16'd63357);
      add_pixel(8'h01, CHK_WRITE, 16'd63358);
      add_pixel(8'h7F, CHK_SKIPPED, '0);
      add_pixel(8'h00, CHK_SKIPPED, '0);
      add_pixel(8'h80, CHK_WRITE, 16'd63678);
      add_pixel(8'h42, CHK_SKIPPED, '0);
      add_pixel(8'h11, CHK_SKIPPED, '0);
      add_pixel(8'h12, CHK_SKIPPED, '0);
      add_pixel(8'h13, CHK_SKIPPED, '0);
      // extreme offsets, wholly off screen
      add_register(tcb_pkg::REG_DEST_X, 11'h400);
      add_register(tcb_pkg::REG_DEST_Y, 11'h3FF);
      add_register(tcb_pkg::REG_SOURCE_WIDTH, 11'd1);
      add_register(tcb_pkg::REG_SOURCE_HEIGHT, 11'd1);
      add_pixel(8'hFF, CHK_SKIPPED, '0);
      // largest source at the origin, one clip row
      add_register(tcb_pkg::REG_DEST_X, 11'd0);
      add_register(tcb_pkg::REG_DEST_Y, 11'd0);
      add_register(tcb_pkg::REG_SOURCE_WIDTH, 11'd1023);
      add_register(tcb_pkg::REG_SOURCE_HEIGHT, 11'd1023);
      add_register(tcb_pkg::REG_KEY_COLOUR, 11'h55);
      add_register(tcb_pkg::REG_CLIP_BOTTOM, 11'd1);
      add_pixel(8'h00, CHK_WRITE, 16'd0);
      add_pixel(8'h55, CHK_SKIPPED, '0);
      add_pixel(8'hAA, CHK_WRITE, 16'd2);
      // size lowered mid-stream: counters past the size, left edge clipped
      add_register(tcb_pkg::REG_DEST_X, 11'h7FF);
      add_register(tcb_pkg::REG_DEST_Y, 11'd5);
      add_register(tcb_pkg::REG_SOURCE_WIDTH, 11'd2);
      add_register(tcb_pkg::REG_SOURCE_HEIGHT, 11'd2);
      add_register(tcb_pkg::REG_KEY_COLOUR, 11'd0);
      add_register(tcb_pkg::REG_CLIP_TOP, 11'd5);
      add_register(tcb_pkg::REG_CLIP_BOTTOM, 11'd6);
      add_pixel(8'h33, CHK_SKIPPED, '0);
      add_pixel(8'h44, CHK_SKIPPED, '0);
      add_pixel(8'h45, CHK_SKIPPED, '0);
      add_pixel(8'h46, CHK_SKIPPED, '0);
      add_pixel(8'h47, CHK_WRITE, 16'd1600);
      // inverted clip window
      add_register(tcb_pkg::REG_DEST_X, 11'd0);
      add_register(tcb_pkg::REG_DEST_Y, 11'd0);
      add_register(tcb_pkg::REG_CLIP_TOP, 11'd200);
      add_register(tcb_pkg::REG_CLIP_BOTTOM, 11'd0);
      add_pixel(8'h10, CHK_SKIPPED, '0);
      // key 255, upper data bits masked off, unused index ignored
      add_register(tcb_pkg::REG_CLIP_TOP, 11'h700);
      add_register(tcb_pkg::REG_CLIP_BOTTOM, 11'h7C8);
      add_register(tcb_pkg::REG_KEY_COLOUR, 11'h7FF);
      add_register(tcb_pkg::REG_SOURCE_WIDTH, 11'h402);
      add_register(tcb_pkg::REG_SOURCE_HEIGHT, 11'h402);
      add_register(REG_UNUSED, 11'h7FF);
      add_pixel(8'hFE, CHK_WRITE, 16'd321);
      add_pixel(8'hFF, CHK_SKIPPED, '0);
      add_pixel(8'h01, CHK_WRITE, 16'd1);

      after_pixel = 1'b0;
      foreach (script[i]) begin
         if (script[i].kind == STEP_REGISTER) begin
            if (after_pixel) settle_block();
            after_pixel = 1'b0;
            write_register(script[i].index, script[i].data);
         end else begin
            after_pixel = 1'b1;
            send_pixel(script[i].pixel, script[i].check, script[i].address);
         end
      end
      settle_block();

      // receiver holds off while pixels keep coming, so the input stalls
      write_register(tcb_pkg::REG_DEST_X, 11'd0);
      write_register(tcb_pkg::REG_DEST_Y, 11'd0);
      write_register(tcb_pkg::REG_SOURCE_WIDTH, 11'd50);
      write_register(tcb_pkg::REG_SOURCE_HEIGHT, 11'd4);
      write_register(tcb_pkg::REG_KEY_COLOUR, 11'd0);
      write_register(tcb_pkg::REG_CLIP_TOP, 11'd0);
      write_register(tcb_pkg::REG_CLIP_BOTTOM, 11'd200);
      hold_requests++;
      repeat (PRESSURE_PIXELS)
         send_pixel(tcb_pkg::COLOUR_W'($urandom_range(1, 255)), CHK_PREDICTED, '0);
      settle_block();

      // random placements under four idling modes
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 77; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 77; end
            default: begin sender_idle_pct = 10; receiver_stall_pct = 10; end
         endcase
         // mostly small sources straddling the frame edges
         dx = $urandom_range(0, 400) - 40;
         dy = $urandom_range(0, 260) - 30;
         w  = $urandom_range(1, 48);
         h  = $urandom_range(1, 24);
         ct = $urandom_range(0, 40);
         cb = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                          : $urandom_range(150, 200);
         case (phase)
            3: begin dx = -1024; dy = -1024; w = 1023; h = 1023; end
            7: begin dx = 1023;  dy = 1023;  w = 0;    h = 0;    end
            11: begin dx = 0; dy = 0; w = 1023; h = 1023; ct = 0; cb = 255; end
            default: ;
         endcase
         phase_key = tcb_pkg::COLOUR_W'($urandom_range(0, 255));
         write_register(tcb_pkg::REG_DEST_X, tcb_pkg::OFFSET_W'(dx));
         write_register(tcb_pkg::REG_DEST_Y, tcb_pkg::OFFSET_W'(dy));
         write_register(tcb_pkg::REG_SOURCE_WIDTH, {1'($urandom), tcb_pkg::SIZE_W'(w)});
         write_register(tcb_pkg::REG_SOURCE_HEIGHT, {1'($urandom), tcb_pkg::SIZE_W'(h)});
         write_register(tcb_pkg::REG_KEY_COLOUR, {3'($urandom), phase_key});
         write_register(tcb_pkg::REG_CLIP_TOP, {3'($urandom), tcb_pkg::CLIP_W'(ct)});
         write_register(tcb_pkg::REG_CLIP_BOTTOM, {3'($urandom), tcb_pkg::CLIP_W'(cb)});
         write_register(REG_UNUSED, tcb_pkg::CSR_DATA_W'($urandom));
         repeat (PHASE_PIXELS) begin
            // a quarter of the pixels carry the key colour
            pixel = ($urandom_range(0, 3) == 0) ? phase_key
                                                : tcb_pkg::COLOUR_W'($urandom_range(0, 255));
            send_pixel(pixel, CHK_PREDICTED, '0);
         end
         settle_block();
      end

      if (pending_writes.size() != 0)
         $display("%0d ns: %0d writes still pending, expected 0", $time,
                  pending_writes.size());
      $display("covered %0d pixels: corner, clip, key and mask cases, a receiver hold-off,",
               pixels_taken);
      $display("and %0d random placements; %0d writes checked, %0d register writes",
               RANDOM_PHASES, writes_checked, register_writes);
      if (error_count == 0 && pending_writes.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
